// ----- design/rlpfd_pkg.sv -----
package rlpfd_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned ColorCount = 3;
  localparam int unsigned GroupCount = 3;
  localparam int unsigned LedsPerGroup = 8;
  localparam int unsigned ShownLeds = GroupCount * LedsPerGroup;
  localparam int unsigned PatternW = ColorCount * LedsPerGroup;
  localparam int unsigned GroupW = 2;

  localparam int unsigned NumLedsDefault = 24;
  localparam int unsigned PwmWrapDefault = 255;
  localparam logic [LevelW-1:0] SyncReset = 8'hAA;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic                                is_tick;
    logic [LevelW-1:0]                   led;
    logic [ColorCount-1:0][LevelW-1:0]   level;
  } cmd_t;

  typedef struct packed {
    logic [GroupW-1:0]   group;
    logic [PatternW-1:0] pattern;
    logic                last;
  } res_t;

endpackage

// ----- design/rlpfd_fifo.sv -----
module rlpfd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW:0]    wr_q, wr_d;
  logic [PtrW:0]    rd_q, rd_d;
  logic             do_push, do_pop;

  assign full_o  = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q[PtrW-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q[PtrW-1:0]] <= data_i;
    end
  end

endmodule

// ----- design/rlpfd_front.sv -----
module rlpfd_front #(
  parameter int unsigned NUM_LEDS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  operation_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i,
  output logic                  cmd_push_o,
  output rlpfd_pkg::cmd_t       cmd_o
);

  import rlpfd_pkg::*;

  localparam int unsigned WindowKeep = 5;
  localparam logic [LevelW:0] NumLedsLim = (LevelW + 1)'(NUM_LEDS);

  logic [LevelW-1:0] win_q [WindowKeep];
  logic [LevelW-1:0] sync_q;
  logic              is_byte;
  logic              frame_hit;

  assign is_byte   = accept_i && (operation_i == OpByte);
  assign frame_hit = (win_q[4] == sync_q) && (rx_byte_i == sync_q) &&
                     ({1'b0, win_q[0]} < NumLedsLim);

  assign cmd_push_o = accept_i && ((operation_i == OpTick) || frame_hit);

  always_comb begin
    cmd_o          = '0;
    cmd_o.is_tick  = (operation_i == OpTick);
    cmd_o.led      = win_q[0];
    cmd_o.level[0] = win_q[1];
    cmd_o.level[1] = win_q[2];
    cmd_o.level[2] = win_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WindowKeep; k++) begin
        win_q[k] <= '0;
      end
      sync_q <= SyncReset;
    end else begin
      if (is_byte) begin
        for (int k = 0; k < WindowKeep - 1; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[WindowKeep-1] <= rx_byte_i;
      end
      if (cfg_we_i) begin
        sync_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- design/rlpfd_back.sv -----
module rlpfd_back #(
  parameter int unsigned NUM_LEDS = 24,
  parameter int unsigned PWM_WRAP = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  rlpfd_pkg::cmd_t  cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output rlpfd_pkg::res_t  res_o
);

  import rlpfd_pkg::*;

  localparam logic [GroupW-1:0] LastGroup = GroupW'(GroupCount - 1);
  localparam logic [LevelW:0]   WrapLim   = (LevelW + 1)'(PWM_WRAP);

  logic [LevelW-1:0] lvl_q [ShownLeds][ColorCount];
  logic [LevelW-1:0] cnt_q, cnt_d;
  logic [GroupW-1:0] grp_q, grp_d;
  logic [LevelW:0]   cnt_inc;
  logic [LevelW-1:0] cnt_nxt;
  logic [LevelW-1:0] cmp_cnt;
  logic [LevelW-1:0] sel_lvl [LedsPerGroup][ColorCount];
  logic              do_write;
  logic              do_emit;

  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign cnt_nxt = (cnt_inc >= WrapLim) ? '0 : cnt_inc[LevelW-1:0];
  assign cmp_cnt = (grp_q == '0) ? cnt_nxt : cnt_q;

  assign do_write = cmd_valid_i && !cmd_i.is_tick;
  assign do_emit  = cmd_valid_i && cmd_i.is_tick && !res_full_i;

  assign cmd_pop_o  = do_write || (do_emit && (grp_q == LastGroup));
  assign res_push_o = do_emit;

  always_comb begin
    for (int i = 0; i < LedsPerGroup; i++) begin
      for (int c = 0; c < ColorCount; c++) begin
        sel_lvl[i][c] = '0;
        for (int g = 0; g < GroupCount; g++) begin
          if (grp_q == GroupW'(g)) begin
            sel_lvl[i][c] = lvl_q[g*LedsPerGroup+i][c];
          end
        end
      end
    end
  end

  always_comb begin
    res_o         = '0;
    res_o.group   = grp_q;
    res_o.last    = (grp_q == LastGroup);
    for (int i = 0; i < LedsPerGroup; i++) begin
      for (int c = 0; c < ColorCount; c++) begin
        res_o.pattern[ColorCount*i+c] = (sel_lvl[i][c] > cmp_cnt);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    grp_d = grp_q;
    if (do_emit) begin
      if (grp_q == '0) begin
        cnt_d = cnt_nxt;
      end
      grp_d = (grp_q == LastGroup) ? '0 : grp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      grp_q <= '0;
      for (int l = 0; l < ShownLeds; l++) begin
        for (int c = 0; c < ColorCount; c++) begin
          lvl_q[l][c] <= '0;
        end
      end
    end else begin
      cnt_q <= cnt_d;
      grp_q <= grp_d;
      if (do_write) begin
        for (int l = 0; l < ShownLeds; l++) begin
          if ((cmd_i.led == LevelW'(l)) && (l < NUM_LEDS)) begin
            for (int c = 0; c < ColorCount; c++) begin
              lvl_q[l][c] <= cmd_i.level[c];
            end
          end
        end
      end
    end
  end

endmodule

// ----- design/rgb_led_pwm_frame_driver_core.sv -----
// Three-color LED PWM driver. Serial bytes shift through a five-byte window; a six-byte frame
// ending in two sync bytes sets the three levels of the LED named by its first byte. A tick
// advances the PWM counter and yields three latch patterns, groups 0 to 2 in order. Bytes are
// taken one per cycle while the command queue is not full. A tick holds the back end until its
// groups are out, one group per cycle while the result queue is not full; a two-entry command
// queue and a four-entry result queue absorb bursts and stalls on either side.
module rgb_led_pwm_frame_driver_core #(
  parameter int unsigned NUM_LEDS = rlpfd_pkg::NumLedsDefault,
  parameter int unsigned PWM_WRAP = rlpfd_pkg::PwmWrapDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  group_o,
  output logic [23:0] pattern_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  import rlpfd_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);

  logic            accept;
  logic            cmd_push;
  cmd_t            cmd_in;
  logic            cmd_full;
  logic            cmd_pop;
  logic            cmd_empty;
  logic [CmdW-1:0] cmd_out_vec;
  cmd_t            cmd_out;
  logic            res_push;
  res_t            res_in;
  logic            res_full;
  logic [ResW-1:0] res_out_vec;
  res_t            res_out;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;
  assign accept      = push && !cmd_full;
  assign cmd_out     = cmd_out_vec;
  assign res_out     = res_out_vec;
  assign group_o     = res_out.group;
  assign pattern_o   = res_out.pattern;
  assign last_o      = res_out.last;

  rlpfd_front #(
    .NUM_LEDS(NUM_LEDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(operation_i),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  rlpfd_fifo #(
    .Width(CmdW),
    .Depth(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out_vec),
    .empty_o(cmd_empty)
  );

  rlpfd_back #(
    .NUM_LEDS(NUM_LEDS),
    .PWM_WRAP(PWM_WRAP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  rlpfd_fifo #(
    .Width(ResW),
    .Depth(4)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out_vec),
    .empty_o(empty)
  );

endmodule

// ----- bench/tb_rgb_led_pwm_frame_driver_core.sv -----
`timescale 1ns / 100ps

module tb_rgb_led_pwm_frame_driver_core;
  import rlpfd_pkg::*;

  localparam int unsigned NumLeds = NumLedsDefault;
  localparam int unsigned PwmWrap = PwmWrapDefault;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        operation = OpByte;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  res_group;
  logic [23:0] res_pattern;
  logic        res_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  logic [7:0]  win_bytes [0:4];
  logic [7:0]  led_level [0:3*NumLeds-1];
  logic [7:0]  pwm_ctr;
  logic [7:0]  sync_byte;
  res_t        latch_expect_q [$];
  int          errors = 0;
  int          items_sent = 0;
  int          ticks_sent = 0;
  bit          quiet = 1'b0;
  int          pop_stall = 0;
  logic        pop_next;
  res_t        got;

  rgb_led_pwm_frame_driver_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation),
    .rx_byte_i   (rx_byte),
    .empty       (empty),
    .pop         (pop),
    .group_o     (res_group),
    .pattern_o   (res_pattern),
    .last_o      (res_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [23:0] latch_pattern(input int unsigned g);
    logic [23:0] pat;
    int unsigned led;
    pat = '0;
    for (int i = 0; i < LedsPerGroup; i++) begin
      led = g * LedsPerGroup + i;
      if (led < NumLeds) begin
        for (int c = 0; c < ColorCount; c++) begin
          if (led_level[led*3+c] > pwm_ctr) begin
            pat[3*i+c] = 1'b1;
          end
        end
      end
    end
    return pat;
  endfunction

  task automatic predict_led_latches(input logic op, input logic [7:0] b);
    int unsigned nxt;
    res_t r;
    if (op == OpByte) begin
      if (win_bytes[4] == sync_byte && b == sync_byte && win_bytes[0] < NumLeds) begin
        for (int k = 0; k < ColorCount; k++) begin
          led_level[win_bytes[0]*3+k] = win_bytes[k+1];
        end
      end
      for (int k = 0; k < 4; k++) begin
        win_bytes[k] = win_bytes[k+1];
      end
      win_bytes[4] = b;
    end else begin
      nxt = pwm_ctr + 1;
      if (nxt >= PwmWrap) begin
        nxt = 0;
      end
      pwm_ctr = nxt[7:0];
      for (int g = 0; g < GroupCount; g++) begin
        r.group = g[1:0];
        r.pattern = latch_pattern(g);
        r.last = (g == GroupCount - 1);
        latch_expect_q.push_back(r);
      end
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] b);
    push <= 1'b1;
    operation <= op;
    rx_byte <= b;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    predict_led_latches(op, b);
    items_sent++;
    if (op == OpTick) begin
      ticks_sent++;
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(OpTick, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input logic [7:0] led, input logic [7:0] l0,
                            input logic [7:0] l1, input logic [7:0] l2);
    send_item(OpByte, led);
    send_item(OpByte, l0);
    send_item(OpByte, l1);
    send_item(OpByte, l2);
    send_item(OpByte, sync_byte);
    send_item(OpByte, sync_byte);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (latch_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    sync_byte = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] any_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames and ticks, with truncated or mis-synced
  // frames and stray bytes mixed in.
  task automatic random_traffic(input int n, input int tick_pct,
                                input int min_ticks, input bit quiet_tail);
    int start;
    int len;
    logic [7:0] led;
    start = items_sent;
    while (items_sent - start < n || ticks_sent < min_ticks) begin
      if (quiet_tail && n - (items_sent - start) < 60 && ticks_sent + 60 >= min_ticks) begin
        quiet = 1'b1;
      end
      led = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, NumLeds - 1));
      if ($urandom_range(0, 99) < tick_pct) begin
        send_tick();
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send_frame(led, any_level(), any_level(), any_level());
          end
          6: begin
            len = $urandom_range(1, 4);
            send_item(OpByte, led);
            repeat (len) send_item(OpByte, any_level());
          end
          7: begin
            send_item(OpByte, led);
            repeat (3) send_item(OpByte, any_level());
            send_item(OpByte, sync_byte ^ 8'($urandom_range(1, 255)));
            send_item(OpByte, sync_byte);
          end
          8: begin
            send_item(OpByte, led);
            repeat (3) send_item(OpByte, any_level());
            send_item(OpByte, sync_byte);
            send_item(OpByte, sync_byte ^ 8'($urandom_range(1, 255)));
          end
          default: begin
            send_item(OpByte, 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  task automatic test_dark_after_reset();
    send_tick();
    send_tick();
  endtask

  task automatic test_frame_edges();
    send_frame(8'd0, 8'hFF, 8'h01, 8'h00);
    send_frame(8'(NumLeds - 1), 8'h00, 8'h80, 8'hFF);
    send_frame(8'(NumLeds), 8'hFF, 8'hFF, 8'hFF);
    send_tick();
    send_tick();
  endtask

  task automatic test_sync_zero();
    write_sync(8'h00);
    random_traffic(50, 30, 0, 1'b0);
  endtask

  task automatic test_sync_max();
    write_sync(8'hFF);
    random_traffic(50, 30, 0, 1'b0);
  endtask

  task automatic test_sync_random();
    write_sync(8'($urandom_range(1, 254)));
    random_traffic(50, 30, 0, 1'b0);
  endtask

  task automatic test_counter_sweep();
    write_sync(SyncReset);
    random_traffic(270, 97, 270, 1'b1);
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (latch_expect_q.size() == 0) begin
          $display("%0t: unexpected result, group %0d pattern %h last %0d", $time,
                   res_group, res_pattern, res_last);
          errors++;
        end else begin
          got = latch_expect_q.pop_front();
          compare_field("group", got.group, res_group);
          compare_field("pattern", got.pattern, res_pattern);
          compare_field("last", got.last, res_last);
        end
      end
      if (pop_stall != 0 && !quiet) begin
        pop_stall--;
        pop_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop_stall = $urandom_range(1, 6) - 1;
        pop_next = 1'b0;
      end else begin
        pop_next = 1'b1;
      end
      pop <= pop_next;
    end
  end

  initial begin
    sync_byte = SyncReset;
    pwm_ctr = '0;
    for (int k = 0; k < 5; k++) begin
      win_bytes[k] = '0;
    end
    for (int k = 0; k < 3 * NumLeds; k++) begin
      led_level[k] = '0;
    end
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_dark_after_reset();
    test_frame_edges();
    test_sync_zero();
    test_sync_max();
    test_sync_random();
    test_counter_sweep();

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && latch_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
